### design/brad_pkg.sv
// Shared types, constants and codes for the broadcast rate alarm detector.
package brad_pkg;

	// Default sizes
	localparam int PORTS_DEF  = 16;
	localparam int WINDOW_DEF = 64;

	// Field widths
	localparam int PORT_W    = 4;
	localparam int COUNTER_W = 64;
	localparam int SECS_W    = 16;
	localparam int RATE_W    = 40;
	localparam int STATUS_W  = 2;
	localparam int ALARM_W   = 2;
	localparam int CFG_W     = 32;
	localparam int SMALL_W   = 7;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W    = 8;

	// Shared divider geometry
	localparam int DIV_NW   = COUNTER_W + FRAC_W;
	localparam int DIV_DW   = SECS_W;
	localparam int DIV_STEP = 4;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_MAX    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_MAX = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_LOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_PCT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_RATE   = 3'd5;

	// Register reset values
	localparam logic [CFG_W-1:0]   RST_RATE_MAX    = 32'd10000;
	localparam logic [CFG_W-1:0]   RST_AVERAGE_MAX = 32'd5000;
	localparam logic [CFG_W-1:0]   RST_AVERAGE_LOW = 32'd500;
	localparam logic [SMALL_W-1:0] RST_RECOVER_PCT = 7'd50;
	localparam logic [SMALL_W-1:0] RST_WINDOW_LEN  = 7'd60;
	localparam logic [CFG_W-1:0]   RST_SKIP_RATE   = 32'd500000;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_PRIMED   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_SKIPPED  = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_MEASURED = 2'd2;

	// Alarm kinds
	localparam logic [ALARM_W-1:0] ALM_NONE  = 2'd0;
	localparam logic [ALARM_W-1:0] ALM_RAW   = 2'd1;
	localparam logic [ALARM_W-1:0] ALM_AVG   = 2'd2;
	localparam logic [ALARM_W-1:0] ALM_SPIKE = 2'd3;

	localparam logic [RATE_W-1:0] RATE_SAT = {RATE_W{1'b1}};

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EVAL,
		ST_RDIV,
		ST_SHRK,
		ST_DROP,
		ST_ADIV,
		ST_CLR,
		ST_MUL,
		ST_ALRM,
		ST_FIN
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load_in;
		logic eval;
		logic rate_take;
		logic drop_rd;
		logic drop_sub;
		logic push;
		logic avg_take;
		logic clr_eval;
		logic mul;
		logic alarm;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic ignore;
		logic measure;
		logic div_done;
		logic drop_need;
		logic hold;
		logic out_free;
	} stat_t;

endpackage

### design/brad_div.sv
// Iterative restoring divider, STEP quotient bits per cycle.
module brad_div #(
	parameter int NW   = brad_pkg::DIV_NW,
	parameter int DW   = brad_pkg::DIV_DW,
	parameter int STEP = brad_pkg::DIV_STEP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] quotient
);

	localparam int ITER = (NW + STEP - 1) / STEP;
	localparam int CNW  = $clog2(ITER + 1);

	logic [NW-1:0]  n_q, n_nx;
	logic [DW-1:0]  r_q, r_nx, d_q;
	logic [CNW-1:0] cnt_q;
	logic           done_q;

	// Shift STEP dividend bits through the partial remainder
	always_comb begin
		logic [DW:0] rw;
		n_nx = n_q;
		r_nx = r_q;
		for (int i = 0; i < STEP; i++) begin
			rw = {r_nx, n_nx[NW-1]};
			n_nx = {n_nx[NW-2:0], 1'b0};
			if (rw >= {1'b0, d_q}) begin
				rw = rw - {1'b0, d_q};
				n_nx[0] = 1'b1;
			end
			r_nx = rw[DW-1:0];
		end
	end

	// Count iterations and flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNW'(ITER);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNW'(1);
			if (cnt_q == CNW'(1)) done_q <= 1'b1;
		end
	end

	// Hold operands and the running quotient
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (cnt_q != '0) begin
			n_q <= n_nx;
			r_q <= r_nx;
		end
	end

	assign done     = done_q;
	assign quotient = n_q;

endmodule

### design/brad_ctrl.sv
// Sequencing state machine for the broadcast rate alarm detector.
module brad_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  brad_pkg::stat_t stat,
	output brad_pkg::cmd_t  cmd
);

	brad_pkg::state_t state_q, state_nx;

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= brad_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			brad_pkg::ST_IDLE: if (s_tvalid) state_nx = brad_pkg::ST_EVAL;
			brad_pkg::ST_EVAL: begin
				if (stat.ignore)       state_nx = brad_pkg::ST_IDLE;
				else if (stat.measure) state_nx = brad_pkg::ST_RDIV;
				else                   state_nx = brad_pkg::ST_FIN;
			end
			brad_pkg::ST_RDIV: if (stat.div_done) state_nx = brad_pkg::ST_SHRK;
			brad_pkg::ST_SHRK: begin
				if (stat.drop_need) state_nx = brad_pkg::ST_DROP;
				else                state_nx = brad_pkg::ST_ADIV;
			end
			brad_pkg::ST_DROP: state_nx = brad_pkg::ST_SHRK;
			brad_pkg::ST_ADIV: if (stat.div_done) state_nx = brad_pkg::ST_CLR;
			brad_pkg::ST_CLR: begin
				if (stat.hold) state_nx = brad_pkg::ST_FIN;
				else           state_nx = brad_pkg::ST_MUL;
			end
			brad_pkg::ST_MUL:  state_nx = brad_pkg::ST_ALRM;
			brad_pkg::ST_ALRM: state_nx = brad_pkg::ST_FIN;
			brad_pkg::ST_FIN:  if (stat.out_free) state_nx = brad_pkg::ST_IDLE;
			default:           state_nx = brad_pkg::ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			brad_pkg::ST_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			brad_pkg::ST_EVAL: cmd.eval = 1'b1;
			brad_pkg::ST_RDIV: cmd.rate_take = stat.div_done;
			brad_pkg::ST_SHRK: begin
				cmd.drop_rd = stat.drop_need;
				cmd.push    = !stat.drop_need;
			end
			brad_pkg::ST_DROP: cmd.drop_sub = 1'b1;
			brad_pkg::ST_ADIV: cmd.avg_take = stat.div_done;
			brad_pkg::ST_CLR:  cmd.clr_eval = 1'b1;
			brad_pkg::ST_MUL:  cmd.mul = 1'b1;
			brad_pkg::ST_ALRM: cmd.alarm = 1'b1;
			brad_pkg::ST_FIN:  cmd.emit = stat.out_free;
			default:           cmd = '0;
		endcase
	end

endmodule

### design/brad_dp.sv
// Datapath: per-port state, sample ring, arithmetic and result register.
module brad_dp #(
	parameter int PORTS  = brad_pkg::PORTS_DEF,
	parameter int WINDOW = brad_pkg::WINDOW_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  brad_pkg::cmd_t                      cmd,
	output brad_pkg::stat_t                     stat,
	input  logic                                cfg_we,
	input  logic [brad_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [brad_pkg::CFG_W-1:0]          cfg_data,
	input  logic [brad_pkg::PORT_W-1:0]         in_port,
	input  logic [brad_pkg::COUNTER_W-1:0]      in_counter,
	input  logic [brad_pkg::SECS_W-1:0]         in_secs,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [brad_pkg::PORT_W-1:0]         out_port,
	output logic [brad_pkg::STATUS_W-1:0]       out_status,
	output logic [brad_pkg::RATE_W-1:0]         out_rate,
	output logic [brad_pkg::RATE_W-1:0]         out_average,
	output logic [brad_pkg::ALARM_W-1:0]        out_kind,
	output logic                                out_raised,
	output logic                                out_cleared
);

	localparam int RW   = brad_pkg::RATE_W;
	localparam int CTW  = brad_pkg::COUNTER_W;
	localparam int PIW  = (PORTS > 1) ? $clog2(PORTS) : 1;
	localparam int SW   = $clog2(WINDOW);
	localparam int CW   = $clog2(WINDOW + 1);
	localparam int SUMW = RW + CW;
	localparam int LENW = (CW > brad_pkg::SMALL_W) ? CW : brad_pkg::SMALL_W;
	localparam int PAW  = RW + CW + 3;
	localparam int PBW  = RW + CW + 4;
	localparam int CLW  = RW + brad_pkg::SMALL_W;

	// Configuration registers
	logic [brad_pkg::CFG_W-1:0]   rate_max_q, avg_max_q, avg_low_q, skip_rate_q;
	logic [brad_pkg::SMALL_W-1:0] recover_q, win_len_q;

	// Per-port state
	logic [CTW-1:0]  last_q [PORTS];
	logic [SW-1:0]   head_q [PORTS];
	logic [CW-1:0]   cnt_q  [PORTS];
	logic [SUMW-1:0] sum_q  [PORTS];
	logic [RW-1:0]   cur_q  [PORTS];
	logic [RW-1:0]   prev_q [PORTS];
	logic [brad_pkg::ALARM_W-1:0] alm_q [PORTS];

	// Sample ring memory, one row of slots per port
	logic [RW-1:0] ring_mem [PORTS * (1 << SW)];
	logic [RW-1:0] ring_rd_q;

	// Item registers
	logic [brad_pkg::PORT_W-1:0]   port_q;
	logic [CTW-1:0]                counter_q;
	logic [brad_pkg::SECS_W-1:0]   secs_q;
	logic [brad_pkg::STATUS_W-1:0] status_q;
	logic [RW-1:0]                 rate_q;
	logic                          raised_q, cleared_q;
	logic [PAW-1:0]                prod_a_q;
	logic [PBW-1:0]                prod_b_q;

	// Result register
	logic                          out_valid_q;
	logic [brad_pkg::PORT_W-1:0]   out_port_q;
	logic [brad_pkg::STATUS_W-1:0] out_status_q;
	logic [RW-1:0]                 out_rate_q, out_avg_q;
	logic [brad_pkg::ALARM_W-1:0]  out_kind_q;
	logic                          out_raised_q, out_cleared_q;

	// Divider interface
	logic                        div_start, div_done;
	logic [brad_pkg::DIV_NW-1:0] div_num, div_q;
	logic [brad_pkg::DIV_DW-1:0] div_den;

	logic [PIW-1:0]              pi;
	logic [brad_pkg::SECS_W-1:0] secs_c;
	logic [CTW-1:0]              lc, wdiff, diff;
	logic                        wrap, skip, prime, ignore;
	logic [CTW-1:0]              skip_lim;
	logic [LENW-1:0]             wl_ext, len_ext;
	logic [CW-1:0]               len, n, cnt_inc;
	logic [SW+1:0]               old_raw;
	logic [SW-1:0]               old_slot, new_slot;
	logic [SUMW-1:0]             sum_new;
	logic [RW-1:0]               cur, prev, rate_sat;
	logic [brad_pkg::ALARM_W-1:0] k;
	logic [CLW-1:0]              clr_lhs, clr_rhs;
	logic                        clr;
	logic [RW-1:0]               rmax_fx, amax_fx, alow_fx;
	logic [CW+2:0]               coef_a;
	logic [CW+3:0]               coef_b;
	logic                        spike;
	logic [brad_pkg::ALARM_W-1:0] kind_new;

	assign pi   = PIW'(port_q);
	assign lc   = last_q[pi];
	assign cur  = cur_q[pi];
	assign prev = prev_q[pi];
	assign k    = alm_q[pi];
	assign n    = cnt_q[pi];

	// Classify the sample
	always_comb begin
		secs_c   = (secs_q == '0) ? brad_pkg::SECS_W'(1) : secs_q;
		ignore   = 32'(port_q) >= PORTS;
		wrap     = counter_q < lc;
		wdiff    = counter_q + ~lc;
		diff     = wrap ? wdiff : (counter_q - lc);
		skip_lim = CTW'(skip_rate_q) * CTW'(secs_c);
		skip     = wrap && (wdiff > skip_lim);
		prime    = (lc == '0);
	end

	// Effective window length and ring slots
	always_comb begin
		wl_ext  = LENW'(win_len_q);
		if (wl_ext == '0)               len_ext = LENW'(1);
		else if (wl_ext > LENW'(WINDOW)) len_ext = LENW'(WINDOW);
		else                            len_ext = wl_ext;
		len      = CW'(len_ext);
		old_raw  = (SW+2)'(head_q[pi]) + (SW+2)'(WINDOW) - (SW+2)'(n - CW'(1));
		old_slot = (old_raw >= (SW+2)'(WINDOW)) ? SW'(old_raw - (SW+2)'(WINDOW))
		                                        : SW'(old_raw);
		new_slot = ((SW+1)'(head_q[pi]) + (SW+1)'(1) == (SW+1)'(WINDOW)) ? '0
		           : head_q[pi] + SW'(1);
		cnt_inc  = n + CW'(1);
		sum_new  = sum_q[pi] + SUMW'(rate_q);
	end

	// Rate saturation, clear rule, alarm rules
	always_comb begin
		rate_sat = (div_q[brad_pkg::DIV_NW-1:RW] != '0) ? brad_pkg::RATE_SAT : div_q[RW-1:0];
		rmax_fx  = {rate_max_q, 8'h00};
		amax_fx  = {avg_max_q, 8'h00};
		alow_fx  = {avg_low_q, 8'h00};
		clr_lhs  = CLW'(rate_q) * CLW'(100);
		clr_rhs  = CLW'(prev) * CLW'(recover_q);
		clr = ((k == brad_pkg::ALM_RAW) && (rate_q < rmax_fx)) ||
		      ((k == brad_pkg::ALM_AVG) && (cur < amax_fx)) ||
		      ((k == brad_pkg::ALM_SPIKE) && (clr_lhs < clr_rhs));
		coef_a = (CW+3)'({len, 3'b000}) - (CW+3)'(n) * (CW+3)'(7);
		coef_b = (CW+4)'(len) * (CW+4)'(10);
		spike  = (prev != '0) && (cur > alow_fx) && (cur > prev) &&
		         (PBW'(prod_a_q) < prod_b_q);
		if (rate_q > rmax_fx)  kind_new = brad_pkg::ALM_RAW;
		else if (cur > amax_fx) kind_new = brad_pkg::ALM_AVG;
		else if (spike)         kind_new = brad_pkg::ALM_SPIKE;
		else                    kind_new = brad_pkg::ALM_NONE;
	end

	// Divider operands: rate at eval, average at push
	always_comb begin
		div_start = (cmd.eval && !ignore && !prime && !skip) || cmd.push;
		if (cmd.push) begin
			div_num = brad_pkg::DIV_NW'(sum_new);
			div_den = brad_pkg::DIV_DW'(cnt_inc);
		end else begin
			div_num = {diff, 8'h00};
			div_den = secs_c;
		end
	end

	brad_div #(
		.NW   (brad_pkg::DIV_NW),
		.DW   (brad_pkg::DIV_DW),
		.STEP (brad_pkg::DIV_STEP)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_q)
	);

	// Configuration and per-port state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_max_q  <= brad_pkg::RST_RATE_MAX;
			avg_max_q   <= brad_pkg::RST_AVERAGE_MAX;
			avg_low_q   <= brad_pkg::RST_AVERAGE_LOW;
			recover_q   <= brad_pkg::RST_RECOVER_PCT;
			win_len_q   <= brad_pkg::RST_WINDOW_LEN;
			skip_rate_q <= brad_pkg::RST_SKIP_RATE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PORTS; i++) begin
				last_q[i] <= '0;
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
				sum_q[i]  <= '0;
				cur_q[i]  <= '0;
				prev_q[i] <= '0;
				alm_q[i]  <= brad_pkg::ALM_NONE;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					brad_pkg::CFG_RATE_MAX:    rate_max_q  <= cfg_data;
					brad_pkg::CFG_AVERAGE_MAX: avg_max_q   <= cfg_data;
					brad_pkg::CFG_AVERAGE_LOW: avg_low_q   <= cfg_data;
					brad_pkg::CFG_RECOVER_PCT: recover_q   <= cfg_data[brad_pkg::SMALL_W-1:0];
					brad_pkg::CFG_WINDOW_LEN:  win_len_q   <= cfg_data[brad_pkg::SMALL_W-1:0];
					brad_pkg::CFG_SKIP_RATE:   skip_rate_q <= cfg_data;
					default: ;
				endcase
			end
			// Store the counter; freeze previous average while alarmed
			if (cmd.eval && !ignore) begin
				last_q[pi] <= counter_q;
				if (!prime && !skip && (k == brad_pkg::ALM_NONE)) prev_q[pi] <= cur;
			end
			// Drop the oldest sample
			if (cmd.drop_sub) begin
				sum_q[pi] <= sum_q[pi] - SUMW'(ring_rd_q);
				cnt_q[pi] <= n - CW'(1);
			end
			// Add the newest sample
			if (cmd.push) begin
				head_q[pi] <= new_slot;
				sum_q[pi]  <= sum_new;
				cnt_q[pi]  <= cnt_inc;
			end
			if (cmd.avg_take) cur_q[pi] <= div_q[RW-1:0];
			// Clear empties the window
			if (cmd.clr_eval && (k != brad_pkg::ALM_NONE) && clr) begin
				alm_q[pi]  <= brad_pkg::ALM_NONE;
				cur_q[pi]  <= rate_q;
				prev_q[pi] <= '0;
				cnt_q[pi]  <= '0;
				sum_q[pi]  <= '0;
			end
			if (cmd.alarm && (kind_new != brad_pkg::ALM_NONE)) alm_q[pi] <= kind_new;
			// Result handshake
			if (cmd.emit)                    out_valid_q <= 1'b1;
			else if (out_ready)              out_valid_q <= 1'b0;
		end
	end

	// Sample ring access
	always_ff @(posedge clk) begin
		if (cmd.push) ring_mem[{pi, new_slot}] <= rate_q;
		if (cmd.drop_rd) ring_rd_q <= ring_mem[{pi, old_slot}];
	end

	// Item payload
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			port_q    <= in_port;
			counter_q <= in_counter;
			secs_q    <= in_secs;
		end
		if (cmd.eval) begin
			rate_q    <= '0;
			raised_q  <= 1'b0;
			cleared_q <= 1'b0;
			if (prime)     status_q <= brad_pkg::STAT_PRIMED;
			else if (skip) status_q <= brad_pkg::STAT_SKIPPED;
			else           status_q <= brad_pkg::STAT_MEASURED;
		end
		if (cmd.rate_take) rate_q <= rate_sat;
		if (cmd.clr_eval && (k != brad_pkg::ALM_NONE) && clr) cleared_q <= 1'b1;
		if (cmd.mul) begin
			prod_a_q <= PAW'(prev) * PAW'(coef_a);
			prod_b_q <= PBW'(cur - prev) * PBW'(coef_b);
		end
		if (cmd.alarm) raised_q <= (kind_new != brad_pkg::ALM_NONE) && !cleared_q;
		if (cmd.emit) begin
			out_port_q    <= port_q;
			out_status_q  <= status_q;
			out_rate_q    <= rate_q;
			out_avg_q     <= cur;
			out_kind_q    <= k;
			out_raised_q  <= raised_q;
			out_cleared_q <= cleared_q;
		end
	end

	// Status to controller
	always_comb begin
		stat.ignore    = ignore;
		stat.measure   = !prime && !skip;
		stat.div_done  = div_done;
		stat.drop_need = n >= len;
		stat.hold      = (k != brad_pkg::ALM_NONE) && !clr;
		stat.out_free  = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign out_port    = out_port_q;
	assign out_status  = out_status_q;
	assign out_rate    = out_rate_q;
	assign out_average = out_avg_q;
	assign out_kind    = out_kind_q;
	assign out_raised  = out_raised_q;
	assign out_cleared = out_cleared_q;

endmodule

### design/broadcast_rate_alarm_detector.sv
// Broadcast rate alarm detector top level: stream ports, controller and datapath.
// A primed or skipped sample needs no division. A measured sample runs the shared divider
// (18 steps of 4 bits) once for the rate and once for the average, adds a drop step per
// dropped window sample, and skips the product and alarm steps while an alarm holds.
// One sample at a time: a new beat is taken only after the last sample's result has moved
// into the result register, which waits while the previous result beat is not taken.
module broadcast_rate_alarm_detector #(
	parameter int PORTS  = brad_pkg::PORTS_DEF,
	parameter int WINDOW = brad_pkg::WINDOW_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// counter_value[63:0], elapsed_seconds[79:64]
	input  logic [79:0]                    s_tdata,
	// port[3:0]
	input  logic [brad_pkg::PORT_W-1:0]    s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// rate[39:0], average[79:40], alarm_kind[81:80], alarm_raised[82],
	// alarm_cleared[83], zero fill[87:84]
	output logic [87:0]                    m_tdata,
	// port_out[3:0], status[5:4]
	output logic [5:0]                     m_tuser,
	input  logic                           cfg_we,
	input  logic [brad_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [brad_pkg::CFG_W-1:0]     cfg_data
);

	brad_pkg::cmd_t  cmd;
	brad_pkg::stat_t stat;

	logic [brad_pkg::PORT_W-1:0]   o_port;
	logic [brad_pkg::STATUS_W-1:0] o_status;
	logic [brad_pkg::RATE_W-1:0]   o_rate, o_avg;
	logic [brad_pkg::ALARM_W-1:0]  o_kind;
	logic                          o_raised, o_cleared;

	brad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	brad_dp #(
		.PORTS  (PORTS),
		.WINDOW (WINDOW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_port     (s_tuser),
		.in_counter  (s_tdata[63:0]),
		.in_secs     (s_tdata[79:64]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_port    (o_port),
		.out_status  (o_status),
		.out_rate    (o_rate),
		.out_average (o_avg),
		.out_kind    (o_kind),
		.out_raised  (o_raised),
		.out_cleared (o_cleared)
	);

	// Pack the result beat
	assign m_tdata = {4'b0000, o_cleared, o_raised, o_kind, o_avg, o_rate};
	assign m_tuser = {o_status, o_port};

endmodule

### dv/testbench.sv
// Self-checking testbench for the broadcast rate alarm detector.
module testbench;

	localparam int NPORT = brad_pkg::PORTS_DEF;
	localparam int NWIN  = brad_pkg::WINDOW_DEF;

	// One expected or observed result beat
	typedef struct {
		logic [brad_pkg::PORT_W-1:0]   port;
		logic [brad_pkg::STATUS_W-1:0] status;
		logic [brad_pkg::RATE_W-1:0]   rate;
		logic [brad_pkg::RATE_W-1:0]   average;
		logic [brad_pkg::ALARM_W-1:0]  kind;
		logic                          raised;
		logic                          cleared;
	} rate_result_t;

	// Per-port rate and alarm predictor with its queue of expected beats
	class alarm_scoreboard;
		logic [31:0] rate_max, average_max, average_low, skip_rate;
		logic [6:0]  recover_pct, window_len;
		logic [63:0] last_count[NPORT];
		logic [63:0] ring[NPORT][NWIN];
		int          head[NPORT];
		int          count[NPORT];
		logic [63:0] sum[NPORT];
		logic [63:0] cur_avg[NPORT];
		logic [63:0] prev_avg[NPORT];
		logic [1:0]  alarm[NPORT];
		rate_result_t expected_q[$];
		int errors, results, raised_cnt, cleared_cnt, skipped_cnt;

		function new();
			rate_max = brad_pkg::RST_RATE_MAX;
			average_max = brad_pkg::RST_AVERAGE_MAX;
			average_low = brad_pkg::RST_AVERAGE_LOW;
			recover_pct = brad_pkg::RST_RECOVER_PCT;
			window_len = brad_pkg::RST_WINDOW_LEN;
			skip_rate = brad_pkg::RST_SKIP_RATE;
			for (int p = 0; p < NPORT; p++) begin
				last_count[p] = 0;
				head[p] = 0;
				count[p] = 0;
				sum[p] = 0;
				cur_avg[p] = 0;
				prev_avg[p] = 0;
				alarm[p] = brad_pkg::ALM_NONE;
				for (int w = 0; w < NWIN; w++) ring[p][w] = 0;
			end
		endfunction

		function void set_reg(logic [brad_pkg::CFG_IDX_W-1:0] idx,
				logic [brad_pkg::CFG_W-1:0] v);
			case (idx)
				brad_pkg::CFG_RATE_MAX:    rate_max = v;
				brad_pkg::CFG_AVERAGE_MAX: average_max = v;
				brad_pkg::CFG_AVERAGE_LOW: average_low = v;
				brad_pkg::CFG_RECOVER_PCT: recover_pct = v[6:0];
				brad_pkg::CFG_WINDOW_LEN:  window_len = v[6:0];
				brad_pkg::CFG_SKIP_RATE:   skip_rate = v;
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Predict the result of one accepted sample beat
		function void note_sample(logic [3:0] p, logic [63:0] cnt, logic [15:0] secs_in);
			logic [63:0] secs, len, diff, q, rate, cur, prev, n;
			rate_result_t r;
			bit chk, clr;
			int old;
			secs = (secs_in == 0) ? 64'd1 : 64'(secs_in);
			len = (window_len == 0) ? 64'd1 : (window_len > NWIN) ? 64'(NWIN) : 64'(window_len);
			rate = 0;
			r.raised = 0;
			r.cleared = 0;
			if (last_count[p] == 0) begin
				last_count[p] = cnt;
				r.status = brad_pkg::STAT_PRIMED;
			end else if (cnt < last_count[p] &&
					(64'hFFFF_FFFF_FFFF_FFFF - last_count[p]) + cnt > 64'(skip_rate) * secs) begin
				last_count[p] = cnt;
				r.status = brad_pkg::STAT_SKIPPED;
				skipped_cnt++;
			end else begin
				if (cnt < last_count[p])
					diff = (64'hFFFF_FFFF_FFFF_FFFF - last_count[p]) + cnt;
				else
					diff = cnt - last_count[p];
				last_count[p] = cnt;
				r.status = brad_pkg::STAT_MEASURED;
				q = diff / secs;
				if (q > 64'hFFFF_FFFF)
					rate = 64'(brad_pkg::RATE_SAT);
				else
					rate = (q << 8) | (((diff % secs) << 8) / secs);
				if (alarm[p] == brad_pkg::ALM_NONE) prev_avg[p] = cur_avg[p];
				// drop oldest samples until the window has room
				while (count[p] >= len) begin
					old = (head[p] + NWIN - (count[p] - 1)) % NWIN;
					sum[p] -= ring[p][old];
					count[p]--;
				end
				head[p] = (head[p] + 1) % NWIN;
				ring[p][head[p]] = rate;
				sum[p] += rate;
				count[p]++;
				cur_avg[p] = sum[p] / count[p];
				chk = 1;
				if (alarm[p] != brad_pkg::ALM_NONE) begin
					clr = (alarm[p] == brad_pkg::ALM_RAW && rate < (64'(rate_max) << 8)) ||
						(alarm[p] == brad_pkg::ALM_AVG &&
							cur_avg[p] < (64'(average_max) << 8)) ||
						(alarm[p] == brad_pkg::ALM_SPIKE &&
							rate * 100 < prev_avg[p] * 64'(recover_pct));
					if (clr) begin
						alarm[p] = brad_pkg::ALM_NONE;
						cur_avg[p] = rate;
						prev_avg[p] = 0;
						count[p] = 0;
						sum[p] = 0;
						r.cleared = 1;
						cleared_cnt++;
					end else begin
						chk = 0;
					end
				end
				if (chk) begin
					cur = cur_avg[p];
					prev = prev_avg[p];
					n = 64'(count[p]);
					if (rate > (64'(rate_max) << 8))
						alarm[p] = brad_pkg::ALM_RAW;
					else if (cur > (64'(average_max) << 8))
						alarm[p] = brad_pkg::ALM_AVG;
					else if (prev != 0 && cur > (64'(average_low) << 8) && cur > prev &&
							prev * (8 * len - 7 * n) < (cur - prev) * 10 * len)
						alarm[p] = brad_pkg::ALM_SPIKE;
					if (alarm[p] != brad_pkg::ALM_NONE && !r.cleared) begin
						r.raised = 1;
						raised_cnt++;
					end
				end
			end
			r.port = p;
			r.rate = rate[brad_pkg::RATE_W-1:0];
			r.average = cur_avg[p][brad_pkg::RATE_W-1:0];
			r.kind = alarm[p];
			expected_q = {expected_q, r};
		endfunction

		function void compare(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				$display("%0t: %s mismatch: expected %0h actual %0h", $time, name, exp_v, act_v);
				errors++;
			end
		endfunction

		// Check one result beat against the oldest expectation
		function void check_result(rate_result_t act);
			rate_result_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result beat: expected none actual port %0h",
					$time, act.port);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			results++;
			compare("port", e.port, act.port);
			compare("status", e.status, act.status);
			compare("rate", e.rate, act.rate);
			compare("average", e.average, act.average);
			compare("alarm_kind", e.kind, act.kind);
			compare("alarm_raised", e.raised, act.raised);
			compare("alarm_cleared", e.cleared, act.cleared);
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [79:0]                    s_tdata;
	logic [brad_pkg::PORT_W-1:0]    s_tuser;
	logic                           m_tvalid;
	logic                           m_tready;
	logic [87:0]                    m_tdata;
	logic [5:0]                     m_tuser;
	logic                           cfg_we;
	logic [brad_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [brad_pkg::CFG_W-1:0]     cfg_data;

	alarm_scoreboard sb;
	bit              idling;
	int              stall_left;
	logic [63:0]     shadow[NPORT];

	broadcast_rate_alarm_detector uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 0;
	always #4 clk = ~clk;

	// Receive result beats, stalling in random bursts
	always @(posedge clk) begin
		rate_result_t act;
		if (m_tvalid && m_tready) begin
			act.rate = m_tdata[39:0];
			act.average = m_tdata[79:40];
			act.kind = m_tdata[81:80];
			act.raised = m_tdata[82];
			act.cleared = m_tdata[83];
			act.port = m_tuser[3:0];
			act.status = m_tuser[5:4];
			sb.check_result(act);
		end
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			m_tready <= 0;
		end else begin
			m_tready <= 1;
		end
	end

	// Send one sample beat; called just after a rising edge
	task automatic send_sample(logic [3:0] p, logic [63:0] cnt, logic [15:0] secs);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {secs, cnt};
		s_tuser <= p;
		do @(posedge clk); while (!s_tready);
		sb.note_sample(p, cnt, secs);
		shadow[p] = cnt;
	endtask

	// Stop sending and wait until every result is back and the block is quiet
	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_regs(logic [31:0] rmax, logic [31:0] amax, logic [31:0] alow,
			logic [6:0] rpct, logic [6:0] wlen, logic [31:0] skip);
		logic [31:0] vals[6];
		vals = '{rmax, amax, alow, 32'(rpct), 32'(wlen), skip};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1;
			cfg_index <= brad_pkg::CFG_IDX_W'(i);
			cfg_data <= vals[i];
			@(posedge clk);
			sb.set_reg(brad_pkg::CFG_IDX_W'(i), vals[i]);
		end
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic [63:0] near(logic [63:0] x);
		logic [63:0] lo;
		lo = x - ((x < x / 8 + 2) ? x : x / 8 + 2);
		return lo + 64'($urandom_range(0, 32'(x / 4 + 4)));
	endfunction

	// Build one random sample, mostly a steady progression with noise mixed in
	task automatic random_sample();
		logic [3:0]  p;
		logic [63:0] pps, cnt;
		logic [15:0] secs;
		int          pick;
		p = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		secs = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom_range(1, 8));
		case ($urandom_range(0, 5))
			0: pps = $urandom_range(0, 20);
			1: pps = near(sb.average_low);
			2: pps = near(sb.average_max);
			3: pps = near(sb.rate_max);
			4: pps = near(64'(sb.rate_max) * 2);
			default: pps = 64'($urandom_range(0, 255)) * 64'($urandom);
		endcase
		if (pick < 72)
			cnt = (shadow[p] == 0) ? 64'($urandom_range(1, 1000)) :
				shadow[p] + pps * ((secs == 0) ? 64'd1 : 64'(secs)) +
				64'($urandom_range(0, (secs == 0) ? 0 : secs - 1));
		else if (pick < 78)
			cnt = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 5000));
		else if (pick < 86)
			cnt = 64'($urandom_range(1, 100000));
		else if (pick < 90)
			cnt = 0;
		else begin
			cnt = {$urandom, $urandom};
			secs = 16'($urandom);
		end
		send_sample(p, cnt, secs);
	endtask

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		sb = new();
		idling = 1;
		stall_left = 0;
		for (int p = 0; p < NPORT; p++) shadow[p] = 0;
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		m_tready = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: priming, zero time, wrap, skip, unprime, saturation, extremes
		send_sample(0, 64'd1, 16'd1);
		send_sample(0, 64'd2001, 16'd2);
		send_sample(0, 64'd2500, 16'd0);
		send_sample(0, 64'd2500, 16'd65535);
		send_sample(1, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
		send_sample(1, 64'd5, 16'd1);
		send_sample(2, 64'h8000_0000_0000_0000, 16'd3);
		send_sample(2, 64'd7, 16'd3);
		send_sample(2, 64'd0, 16'd1);
		send_sample(2, 64'd900, 16'd1);
		send_sample(3, 64'd1, 16'd1);
		send_sample(3, 64'hFFFF_FFFF_FFFF_FFFF, 16'd1);
		send_sample(15, 64'd10, 16'd65535);
		send_sample(15, 64'd10 + 64'd20000 * 64'd65535, 16'd65535);
		send_sample(15, 64'd10 + 64'd20000 * 64'd65535 + 64'd40000, 16'd1);
		send_sample(15, 64'd10 + 64'd20000 * 64'd65535 + 64'd41000, 16'd1);
		drain();

		// Phases of settings, extremes among them; shrink window between phases
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_regs(1000, 600, 50, 50, 64, 500000);
				1: write_regs(0, 0, 0, 0, 1, 0);
				2: write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 100, 127,
					32'hFFFF_FFFF);
				3: write_regs(2000, 1500, 100, 127, 8, 1000);
				default: write_regs(500, 300, 20, 80, 0, 100000);
			endcase
			idling = (ph != 4);
			for (int i = 0; i < 80; i++) begin
				if (ph == 0 && i == 40) drain();
				random_sample();
			end
			drain();
		end

		$display("Checked %0d results: %0d alarms raised, %0d cleared, %0d counter resets skipped",
			sb.results, sb.raised_cnt, sb.cleared_cnt, sb.skipped_cnt);
		$display("Covered six register settings, window shrink, wraps and saturation");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

### broadcast_rate_alarm_detector.f
design/brad_pkg.sv
design/brad_div.sv
design/brad_ctrl.sv
design/brad_dp.sv
design/broadcast_rate_alarm_detector.sv
dv/testbench.sv
